[design/text_stream_display_filter_core_macros.svh]
// Assertion macros shared by the filter's modules.
`ifndef TEXT_STREAM_DISPLAY_FILTER_CORE_MACROS_SVH
`define TEXT_STREAM_DISPLAY_FILTER_CORE_MACROS_SVH

`ifndef SYNTH
`define TSDF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsdf: check failed");
`define TSDF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsdf: check failed");
`else
`define TSDF_ASSERT_IMP(label, clk, rst, ante, cons)
`define TSDF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

[design/tsdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsdf_pkg;

   localparam int NUMBER_DIGITS_DEF = 6;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam int BYTE_W = 8;
   localparam int CSR_W  = 3;
   localparam int CSR_DATA_W = 1;

   localparam logic [CSR_W-1:0] CSR_SQUEEZE_BLANK    = 3'd0;
   localparam logic [CSR_W-1:0] CSR_NUMBER_ALL       = 3'd1;
   localparam logic [CSR_W-1:0] CSR_NUMBER_NONBLANK  = 3'd2;
   localparam logic [CSR_W-1:0] CSR_SHOW_ENDS        = 3'd3;
   localparam logic [CSR_W-1:0] CSR_SHOW_NONPRINTING = 3'd4;
   localparam logic [CSR_W-1:0] CSR_SHOW_TABS        = 3'd5;

   localparam logic [BYTE_W-1:0] CH_TAB    = 8'd9;
   localparam logic [BYTE_W-1:0] CH_NL     = 8'd10;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'd32;
   localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'd36;
   localparam logic [BYTE_W-1:0] CH_DASH   = 8'd45;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'd48;
   localparam logic [BYTE_W-1:0] CH_QUERY  = 8'd63;
   localparam logic [BYTE_W-1:0] CH_UPPER_I = 8'd73;
   localparam logic [BYTE_W-1:0] CH_UPPER_M = 8'd77;
   localparam logic [BYTE_W-1:0] CH_CARET  = 8'd94;

   typedef struct packed {
      logic squeeze_blank;
      logic number_all;
      logic number_nonblank;
      logic show_ends;
      logic show_nonprinting;
      logic show_tabs;
   } tsdf_cfg_type;

   // One classified request as the back end replays it.
   typedef struct packed {
      logic              number;
      logic              dollar;
      logic              mprefix;
      logic              caret;
      logic [BYTE_W-1:0] ch;
   } tsdf_desc_type;

   typedef enum logic [2:0] {
      PH_DIGIT,
      PH_TAB,
      PH_DOLLAR,
      PH_MCHAR,
      PH_DASH,
      PH_CARET,
      PH_CHAR
   } tsdf_phase_type;

   function automatic tsdf_phase_type after_dollar(input tsdf_desc_type d);
      tsdf_phase_type p;
      if (d.mprefix) begin
         p = PH_MCHAR;
      end else if (d.caret) begin
         p = PH_CARET;
      end else begin
         p = PH_CHAR;
      end
      return p;
   endfunction

   function automatic tsdf_phase_type after_number(input tsdf_desc_type d);
      tsdf_phase_type p;
      if (d.dollar) begin
         p = PH_DOLLAR;
      end else begin
         p = after_dollar(d);
      end
      return p;
   endfunction

   function automatic tsdf_phase_type first_phase(input tsdf_desc_type d);
      tsdf_phase_type p;
      if (d.number) begin
         p = PH_DIGIT;
      end else begin
         p = after_number(d);
      end
      return p;
   endfunction

endpackage

`default_nettype wire

[design/tsdf_channels.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tsdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface tsdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_item;

   modport source (output valid, output out_char, output last_of_item, input ready);
   modport sink   (input valid, input out_char, input last_of_item, output ready);
endinterface

`default_nettype wire

[design/tsdf_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsdf_front
   import tsdf_pkg::*;
#(
   parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [CSR_W-1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_wdata,
   tsdf_req_if.sink                         req_chan,
   input  wire logic                        queue_full,
   output logic                             push,
   output tsdf_desc_type                    push_desc,
   output logic [NUMBER_DIGITS*4-1:0]       push_digits
);

   localparam int CNT_W = NUMBER_DIGITS * 4;

   tsdf_cfg_type       cfg_ff, cfg_in;
   logic [BYTE_W-1:0]  prev_ff, prev_in;
   logic [BYTE_W-1:0]  prev2_ff, prev2_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [BYTE_W-1:0]  c;
   logic [6:0]         low;
   logic               at_start, drop, numbering, accept;
   logic               all_nine, carry;
   logic [CNT_W-1:0]   count_inc;
   tsdf_desc_type      desc;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_wdata[0];
            CSR_NUMBER_ALL:       cfg_in.number_all       = csr_wdata[0];
            CSR_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_wdata[0];
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_wdata[0];
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_wdata[0];
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // BCD increment, sticking at all nines
   always_comb begin
      all_nine  = 1'b1;
      carry     = 1'b1;
      count_inc = count_ff;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (count_ff[i*4 +: 4] != 4'd9) begin
            all_nine = 1'b0;
         end
         if (carry) begin
            if (count_ff[i*4 +: 4] >= 4'd9) begin
               count_inc[i*4 +: 4] = 4'd0;
            end else begin
               count_inc[i*4 +: 4] = count_ff[i*4 +: 4] + 4'd1;
               carry = 1'b0;
            end
         end
      end
   end

   always_comb begin
      c         = req_chan.in_byte;
      low       = c[6:0];
      at_start  = (prev_ff == CH_NL);
      drop      = cfg_ff.squeeze_blank && at_start && (c == CH_NL) && (prev2_ff == CH_NL);
      numbering = at_start && (cfg_ff.number_all || (cfg_ff.number_nonblank && c != CH_NL));
      accept    = req_chan.valid && !queue_full;

      desc.number  = numbering;
      desc.dollar  = cfg_ff.show_ends && (c == CH_NL);
      desc.mprefix = 1'b0;
      desc.caret   = 1'b0;
      desc.ch      = c;
      if (cfg_ff.show_tabs && c == CH_TAB) begin
         desc.caret = 1'b1;
         desc.ch    = CH_UPPER_I;
      end else if (cfg_ff.show_nonprinting) begin
         desc.mprefix = c[7];
         desc.ch      = {1'b0, low};
         if (low == 7'd127) begin
            desc.caret = 1'b1;
            desc.ch    = CH_QUERY;
         end else if (low < 7'd32 &&
                      (c[7] || ({1'b0, low} != CH_TAB && {1'b0, low} != CH_NL))) begin
            desc.caret = 1'b1;
            desc.ch    = {1'b0, low} + 8'd64;
         end
      end

      prev_in  = prev_ff;
      prev2_in = prev2_ff;
      count_in = count_ff;
      if (accept && !drop) begin
         prev_in  = c;
         prev2_in = prev_ff;
         if (numbering && !all_nine) begin
            count_in = count_inc;
         end
      end
   end

   assign req_chan.ready = !queue_full;
   assign push           = accept && !drop;
   assign push_desc      = desc;
   assign push_digits    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '0;
         prev_ff  <= CH_NL;
         prev2_ff <= '0;
         count_ff <= CNT_W'(1);
      end else begin
         cfg_ff   <= cfg_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[design/tsdf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "text_stream_display_filter_core_macros.svh"

module tsdf_queue
   import tsdf_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TSDF_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `TSDF_ASSERT_NXT(a_fill, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

[design/tsdf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "text_stream_display_filter_core_macros.svh"

module tsdf_back
   import tsdf_pkg::*;
#(
   parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       head_valid,
   input  wire tsdf_desc_type              head_desc,
   input  wire logic [NUMBER_DIGITS*4-1:0] head_digits,
   output logic                            pop,
   tsdf_rsp_if.source                      rsp_chan
);

   localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

   tsdf_phase_type    phase_ff, phase_in, cur_phase;
   logic              busy_ff, busy_in;
   logic [DIG_W-1:0]  digit_ff, digit_in, cur_digit;
   logic              lead_ff, lead_in, cur_lead;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              advance;
   logic [3:0]        dig;
   logic [BYTE_W-1:0] out_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CHAR;
         busy_ff      <= 1'b0;
         digit_ff     <= '0;
         lead_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         busy_ff      <= busy_in;
         digit_ff     <= digit_in;
         lead_ff      <= lead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      // a fresh head starts at its first phase and the top digit
      cur_phase = busy_ff ? phase_ff : first_phase(head_desc);
      cur_digit = busy_ff ? digit_ff : DIG_W'(NUMBER_DIGITS - 1);
      cur_lead  = busy_ff ? lead_ff : 1'b1;
      advance   = head_valid && (!rsp_valid_ff || rsp_chan.ready);

      dig = head_digits[cur_digit*4 +: 4];
      if (dig > 4'd9) begin
         dig = 4'd9;
      end

      phase_in     = phase_ff;
      busy_in      = busy_ff;
      digit_in     = digit_ff;
      lead_in      = lead_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      out_byte     = head_desc.ch;

      case (cur_phase)
         PH_DIGIT: begin
            if (cur_lead && dig == 4'd0 && cur_digit != '0) begin
               out_byte = CH_SPACE;
            end else begin
               out_byte = CH_ZERO + {4'd0, dig};
            end
         end
         PH_TAB:    out_byte = CH_TAB;
         PH_DOLLAR: out_byte = CH_DOLLAR;
         PH_MCHAR:  out_byte = CH_UPPER_M;
         PH_DASH:   out_byte = CH_DASH;
         PH_CARET:  out_byte = CH_CARET;
         PH_CHAR:   out_byte = head_desc.ch;
         default:   out_byte = head_desc.ch;
      endcase

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = out_byte;
         rsp_last_in  = (cur_phase == PH_CHAR);
         busy_in      = (cur_phase != PH_CHAR);
         pop          = (cur_phase == PH_CHAR);
         digit_in     = cur_digit;
         lead_in      = cur_lead;
         case (cur_phase)
            PH_DIGIT: begin
               if (out_byte != CH_SPACE) begin
                  lead_in = 1'b0;
               end
               if (cur_digit == '0) begin
                  phase_in = PH_TAB;
               end else begin
                  phase_in = PH_DIGIT;
                  digit_in = cur_digit - 1'b1;
               end
            end
            PH_TAB:    phase_in = after_number(head_desc);
            PH_DOLLAR: phase_in = after_dollar(head_desc);
            PH_MCHAR:  phase_in = PH_DASH;
            PH_DASH:   phase_in = head_desc.caret ? PH_CARET : PH_CHAR;
            PH_CARET:  phase_in = PH_CHAR;
            PH_CHAR:   phase_in = PH_CHAR;
            default:   phase_in = PH_CHAR;
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_char     = rsp_char_ff;
   assign rsp_chan.last_of_item = rsp_last_ff;

   `TSDF_ASSERT_IMP(a_busy_has_head, clock, reset, busy_ff, head_valid)
   `TSDF_ASSERT_IMP(a_digit_numbered, clock, reset, busy_ff && phase_ff == PH_DIGIT, head_desc.number)

endmodule

`default_nettype wire

[design/text_stream_display_filter_core.sv]
// Channel | Dir | Payload                   | Handshake
// req     | in  | in_byte[7:0]              | valid/ready
// rsp     | out | out_char[7:0], last_of_item| valid/ready
// csr     | in  | csr_index[2:0], csr_wdata | csr_we, no stall
//
// A request expands to 1 to NUMBER_DIGITS + 5 output bytes, which the byte
// sequencer in the back end sends one after another.
// The front end classifies and takes one request per cycle while the queue
// (QUEUE_DEPTH entries) has room; a squeezed newline is taken with no output.
// Synchronous active-high reset clears options, line state, queue and output.
// While rsp is stalled the output register holds its byte, the back end waits
// and the front end keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module text_stream_display_filter_core
   import tsdf_pkg::*;
#(
   parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   tsdf_req_if.sink                   req_chan,
   tsdf_rsp_if.source                 rsp_chan
);

   localparam int CNT_W   = NUMBER_DIGITS * 4;
   localparam int DESC_W  = $bits(tsdf_desc_type);
   localparam int ENTRY_W = CNT_W + DESC_W;

   logic               push, pop, queue_full, head_valid;
   tsdf_desc_type      push_desc, head_desc;
   logic [CNT_W-1:0]   push_digits, head_digits;
   logic [ENTRY_W-1:0] head_data;

   tsdf_front #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_chan    (req_chan),
      .queue_full  (queue_full),
      .push        (push),
      .push_desc   (push_desc),
      .push_digits (push_digits)
   );

   tsdf_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_digits, push_desc}),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign head_desc   = tsdf_desc_type'(head_data[DESC_W-1:0]);
   assign head_digits = head_data[ENTRY_W-1:DESC_W];

   tsdf_back #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_desc   (head_desc),
      .head_digits (head_digits),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire
